>>> rtl/core/gregorian_date_day_number_macros.svh
// Assertion macros for the Gregorian date arithmetic block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef GREGORIAN_DATE_DAY_NUMBER_MACROS_SVH
`define GREGORIAN_DATE_DAY_NUMBER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDDN_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GDDN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gddn_pkg.sv
// Package for the Gregorian date arithmetic block: constants, stage types and
// calendar helper functions. No dependencies.
package gddn_pkg;

  typedef enum logic [1:0] {
    ActDateToDays = 2'd0,
    ActDaysToDate = 2'd1,
    ActDatePlus   = 2'd2,
    ActDateDiff   = 2'd3
  } action_e;

  localparam logic [11:0] MinYear    = 12'd1900;
  localparam logic [11:0] MaxYear    = 12'd2200;
  localparam logic [16:0] MaxDayNum  = 17'd109937;
  localparam logic [16:0] DaysInYear = 17'd365;
  // Offsets of the years 2100 and 2200, which are not leap years.
  localparam logic [8:0]  Off2100    = 9'd200;
  localparam logic [8:0]  Off2200    = 9'd300;
  // ceil(2^34 / 1461): n * YearRecip >> 32 is floor(4n / 1461) for n < 2^17.
  localparam int          RecipShift = 32;
  localparam int          ProdW      = 41;
  localparam logic [23:0] YearRecip  = 24'd11758980;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [8:0] CumDays [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    action_e     act;
    logic [4:0]  day_a;
    logic [3:0]  month_a;
    logic [11:0] year_a;
    logic [4:0]  day_b;
    logic [3:0]  month_b;
    logic [11:0] year_b;
    logic [17:0] day_count;
  } in_stage_t;

  typedef struct packed {
    action_e     act;
    logic        ok_a;
    logic        ok_b;
    logic [16:0] num_a;
    logic [16:0] num_b;
    logic [17:0] day_count;
  } num_stage_t;

  typedef struct packed {
    logic        has_date;
    logic        bad;
    logic [17:0] days;
    logic [16:0] nd;
  } sel_stage_t;

  typedef struct packed {
    logic        has_date;
    logic        bad;
    logic [17:0] days;
    logic [16:0] nd;
    logic [8:0]  k0;
  } est_stage_t;

  typedef struct packed {
    logic        has_date;
    logic        bad;
    logic [17:0] days;
    logic [16:0] nd;
    logic [8:0]  k0;
    logic [16:0] ys0;
    logic [16:0] ys1;
  } ys_stage_t;

  typedef struct packed {
    logic        has_date;
    logic        bad;
    logic [17:0] days;
    logic [8:0]  k;
    logic [8:0]  rem;
    logic        leap;
  } rem_stage_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [17:0] days;
    logic        bad;
    logic        has_date;
  } out_stage_t;

  typedef struct packed {
    logic        ok;
    logic [16:0] num;
  } date_num_t;

  // Leap test on a year given as offset from 1900, valid for offsets 0 to 300.
  function automatic logic is_leap(logic [8:0] k);
    return (k[1:0] == 2'b00) && (k != 9'd0) && (k != Off2100) && (k != Off2200);
  endfunction

  // Day number of January 1 of year 1900 + k.
  function automatic logic [16:0] year_start(logic [8:0] k);
    logic [9:0] kp3;
    logic [7:0] leaps;
    kp3   = {1'b0, k} + 10'd3;
    leaps = kp3[9:2] - 8'(k != 9'd0) - 8'(k > Off2100);
    return (17'(k) * DaysInYear) + 17'(leaps);
  endfunction

  // Days before the month with zero-based index idx.
  function automatic logic [8:0] cum_days(logic [3:0] idx, logic leap);
    return CumDays[idx] + 9'(leap && (idx >= 4'd2));
  endfunction

  // Range check of a date and its day number (meaningful only when ok).
  function automatic date_num_t date_eval(logic [4:0] d, logic [3:0] m, logic [11:0] y);
    date_num_t  res;
    logic       yr_ok;
    logic       mo_ok;
    logic [8:0] k;
    logic       leap;
    logic [3:0] idx;
    logic [4:0] mlen;
    yr_ok   = (y >= MinYear) && (y <= MaxYear);
    mo_ok   = (m >= 4'd1) && (m <= 4'd12);
    k       = 9'(y - MinYear);
    leap    = is_leap(k);
    idx     = mo_ok ? (m - 4'd1) : 4'd0;
    mlen    = MonthLen[idx] + 5'((idx == 4'd1) && leap);
    res.ok  = yr_ok && mo_ok && (d != 5'd0) && (d <= mlen);
    res.num = year_start(k) + 17'(cum_days(idx, leap)) + 17'(d) - 17'd1;
    return res;
  endfunction

endpackage

>>> rtl/core/gregorian_date_day_number.sv
// Gregorian date arithmetic over the years 1900 to 2200, as a seven-register pipeline.
// Depends on gddn_pkg and gregorian_date_day_number_macros.svh.
//
//   Channel  | Dir | Contents
//   s_axis   | in  | tuser: action; tdata: date A, date B, day count
//   m_axis   | out | tuser: invalid flag; tdata: day, month, year, day number
//
// One transaction per cycle sustained unless the output stalls; a result passes the
// in, s1-s5 and out registers in turn. The depth is set by the year estimate: a
// constant reciprocal multiply, then one correction compare, then the month search.
// Every stage holds its item while the next one is full and stalled, and takes a new
// item whenever it is empty or moving on. Reset clears all stage valid bits.
`include "gregorian_date_day_number_macros.svh"

module gregorian_date_day_number (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // day_a[4:0], month_a[8:5], year_a[20:9], day_b[25:21], month_b[29:26],
  // year_b[41:30], day_count[59:42], zero fill[63:60]
  input  logic [63:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_day[4:0], out_month[8:5], out_year[20:9], out_days[38:21], zero fill[39]
  output logic [39:0] m_axis_tdata,
  // invalid[0]
  output logic        m_axis_tuser
);

  gddn_pkg::in_stage_t  in_d, in_q;
  gddn_pkg::num_stage_t s1_d, s1_q;
  gddn_pkg::sel_stage_t s2_d, s2_q;
  gddn_pkg::est_stage_t s3_d, s3_q;
  gddn_pkg::ys_stage_t  s4_d, s4_q;
  gddn_pkg::rem_stage_t s5_d, s5_q;
  gddn_pkg::out_stage_t out_d, out_q;

  logic in_v_d, in_v_q, s1_v_d, s1_v_q, s2_v_d, s2_v_q, s3_v_d, s3_v_q;
  logic s4_v_d, s4_v_q, s5_v_d, s5_v_q, out_v_d, out_v_q;
  logic in_rdy, s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, out_rdy;

  // A stage may load when it is empty or its content moves on this cycle.
  assign out_rdy = !out_v_q || m_axis_tready;
  assign s5_rdy  = !s5_v_q || out_rdy;
  assign s4_rdy  = !s4_v_q || s5_rdy;
  assign s3_rdy  = !s3_v_q || s4_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign in_rdy  = !in_v_q || s1_rdy;

  assign s_axis_tready = in_rdy;

  assign in_v_d  = in_rdy  ? s_axis_tvalid : in_v_q;
  assign s1_v_d  = s1_rdy  ? in_v_q        : s1_v_q;
  assign s2_v_d  = s2_rdy  ? s1_v_q        : s2_v_q;
  assign s3_v_d  = s3_rdy  ? s2_v_q        : s3_v_q;
  assign s4_v_d  = s4_rdy  ? s3_v_q        : s4_v_q;
  assign s5_v_d  = s5_rdy  ? s4_v_q        : s5_v_q;
  assign out_v_d = out_rdy ? s5_v_q        : out_v_q;

  // Input unpacking.
  always_comb begin
    in_d.act       = gddn_pkg::action_e'(s_axis_tuser);
    in_d.day_a     = s_axis_tdata[4:0];
    in_d.month_a   = s_axis_tdata[8:5];
    in_d.year_a    = s_axis_tdata[20:9];
    in_d.day_b     = s_axis_tdata[25:21];
    in_d.month_b   = s_axis_tdata[29:26];
    in_d.year_b    = s_axis_tdata[41:30];
    in_d.day_count = s_axis_tdata[59:42];
  end

  // Date checks and day numbers of both dates.
  gddn_pkg::date_num_t eval_a, eval_b;
  always_comb begin
    eval_a          = gddn_pkg::date_eval(in_q.day_a, in_q.month_a, in_q.year_a);
    eval_b          = gddn_pkg::date_eval(in_q.day_b, in_q.month_b, in_q.year_b);
    s1_d.act        = in_q.act;
    s1_d.ok_a       = eval_a.ok;
    s1_d.ok_b       = eval_b.ok;
    s1_d.num_a      = eval_a.num;
    s1_d.num_b      = eval_b.num;
    s1_d.day_count  = in_q.day_count;
  end

  // Select the day number or difference and check its range.
  logic signed [18:0] num_a_s, num_b_s, cnt_s, n_sel;
  logic               range_bad, bad_sel, has_date_sel;
  always_comb begin
    num_a_s      = signed'({2'b00, s1_q.num_a});
    num_b_s      = signed'({2'b00, s1_q.num_b});
    cnt_s        = signed'({s1_q.day_count[17], s1_q.day_count});
    n_sel        = num_a_s;
    bad_sel      = 1'b0;
    has_date_sel = 1'b0;
    range_bad    = 1'b0;
    unique case (s1_q.act)
      gddn_pkg::ActDateToDays: begin
        n_sel   = num_a_s;
        bad_sel = !s1_q.ok_a;
      end
      gddn_pkg::ActDateDiff: begin
        n_sel   = num_a_s - num_b_s;
        bad_sel = !(s1_q.ok_a && s1_q.ok_b);
      end
      gddn_pkg::ActDaysToDate: begin
        n_sel        = cnt_s;
        has_date_sel = 1'b1;
      end
      gddn_pkg::ActDatePlus: begin
        n_sel        = num_a_s + cnt_s;
        bad_sel      = !s1_q.ok_a;
        has_date_sel = 1'b1;
      end
      default: begin
        n_sel = num_a_s;
      end
    endcase
    if (has_date_sel) begin
      range_bad = (n_sel < 19'sd0) || (n_sel > signed'({2'b00, gddn_pkg::MaxDayNum}));
    end
    s2_d.has_date = has_date_sel;
    s2_d.bad      = bad_sel || range_bad;
    s2_d.days     = s2_d.bad ? 18'd0 : n_sel[17:0];
    s2_d.nd       = (s2_d.bad || !has_date_sel) ? 17'd0 : n_sel[16:0];
  end

  // Year estimate floor(4n / 1461): exact or one year low.
  logic [gddn_pkg::ProdW-1:0] est_prod;
  always_comb begin
    est_prod      = gddn_pkg::ProdW'(s2_q.nd) * gddn_pkg::ProdW'(gddn_pkg::YearRecip);
    s3_d.has_date = s2_q.has_date;
    s3_d.bad      = s2_q.bad;
    s3_d.days     = s2_q.days;
    s3_d.nd       = s2_q.nd;
    s3_d.k0       = est_prod[gddn_pkg::RecipShift +: 9];
  end

  // Year starts of the estimate and the year after it.
  always_comb begin
    s4_d.has_date = s3_q.has_date;
    s4_d.bad      = s3_q.bad;
    s4_d.days     = s3_q.days;
    s4_d.nd       = s3_q.nd;
    s4_d.k0       = s3_q.k0;
    s4_d.ys0      = gddn_pkg::year_start(s3_q.k0);
    s4_d.ys1      = gddn_pkg::year_start(s3_q.k0 + 9'd1);
  end

  // Correct the year and form the day within the year.
  logic        step_up;
  logic [16:0] rem_full;
  always_comb begin
    step_up       = s4_q.nd >= s4_q.ys1;
    rem_full      = s4_q.nd - (step_up ? s4_q.ys1 : s4_q.ys0);
    s5_d.has_date = s4_q.has_date;
    s5_d.bad      = s4_q.bad;
    s5_d.days     = s4_q.days;
    s5_d.k        = step_up ? (s4_q.k0 + 9'd1) : s4_q.k0;
    s5_d.rem      = rem_full[8:0];
    s5_d.leap     = gddn_pkg::is_leap(s5_d.k);
  end

  // Month search: the last month whose start is not past the day of year.
  logic [3:0] mon_idx;
  logic [8:0] day_of_mon;
  logic       show_date;
  always_comb begin
    mon_idx = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (s5_q.rem >= gddn_pkg::cum_days(4'(i), s5_q.leap)) begin
        mon_idx = 4'(i);
      end
    end
    day_of_mon     = s5_q.rem - gddn_pkg::cum_days(mon_idx, s5_q.leap) + 9'd1;
    show_date      = s5_q.has_date && !s5_q.bad;
    out_d.day      = show_date ? day_of_mon[4:0] : 5'd0;
    out_d.month    = show_date ? (mon_idx + 4'd1) : 4'd0;
    out_d.year     = show_date ? (gddn_pkg::MinYear + 12'(s5_q.k)) : 12'd0;
    out_d.days     = s5_q.days;
    out_d.bad      = s5_q.bad;
    out_d.has_date = s5_q.has_date;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      s3_v_q  <= s3_v_d;
      s4_v_q  <= s4_v_d;
      s5_v_q  <= s5_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy) begin
      in_q <= in_d;
    end
    if (s1_rdy) begin
      s1_q <= s1_d;
    end
    if (s2_rdy) begin
      s2_q <= s2_d;
    end
    if (s3_rdy) begin
      s3_q <= s3_d;
    end
    if (s4_rdy) begin
      s4_q <= s4_d;
    end
    if (s5_rdy) begin
      s5_q <= s5_d;
    end
    if (out_rdy) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_q.days, out_q.year, out_q.month, out_q.day};
  assign m_axis_tuser  = out_q.bad;

  `GDDN_ASSERT_IMPLY(a_bad_result_zero, out_v_q && out_q.bad,
    (out_q.day == 5'd0) && (out_q.month == 4'd0) && (out_q.year == 12'd0) &&
    (out_q.days == 18'd0), "invalid result carries nonzero fields")
  `GDDN_ASSERT_IMPLY(a_date_in_range, out_v_q && !out_q.bad && out_q.has_date,
    (out_q.month >= 4'd1) && (out_q.month <= 4'd12) && (out_q.day != 5'd0) &&
    (out_q.year >= gddn_pkg::MinYear) && (out_q.year <= gddn_pkg::MaxYear),
    "converted date out of range")
  `GDDN_ASSERT_IMPLY(a_estimate_not_high, s4_v_q && s4_q.has_date && !s4_q.bad,
    s4_q.ys0 <= s4_q.nd, "year estimate past the day number")
  `GDDN_ASSERT_IMPLY(a_day_of_year, s5_v_q && s5_q.has_date && !s5_q.bad,
    s5_q.rem <= (s5_q.leap ? 9'd365 : 9'd364), "day of year past year end")
  `GDDN_ASSERT_NEXT(a_stall_keeps_item, in_v_q && !s1_rdy, in_v_q,
    "input stage dropped a stalled item")

endmodule

>>> tb/sv/tb_gregorian_date_day_number.sv
`timescale 1ns / 100ps
// Self-checking testbench for gregorian_date_day_number: date to day number, day number
// to date, date plus offset and date difference, checked against an in-bench calendar model.
// Depends on gddn_pkg for the action codes; needs only the RTL.

module tb_gregorian_date_day_number;

  localparam int FirstYear   = 1900;
  localparam int LastYear    = 2200;
  localparam int LastDayNum  = 109937;
  localparam int PipeLatency = 7;
  localparam int LongHold    = 60;
  localparam int DrainLimit  = 5000;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [17:0] days;
    logic        bad;
  } date_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // day_a[4:0], month_a[8:5], year_a[20:9], day_b[25:21], month_b[29:26],
  // year_b[41:30], day_count[59:42], zero fill[63:60]
  logic [63:0] s_axis_tdata;
  // action[1:0]
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // out_day[4:0], out_month[8:5], out_year[20:9], out_days[38:21], zero fill[39]
  logic [39:0] m_axis_tdata;
  // invalid[0]
  logic        m_axis_tuser;

  date_result_t expected_q[$];
  date_result_t exp_res;
  int  n_errors  = 0;
  int  n_sent    = 0;
  int  n_checked = 0;
  bit  idle_en   = 1'b0;
  int  hold_seq  = 0;
  int  seen_seq  = 0;
  int  hold_cnt  = 0;
  int  stall_cnt = 0;

  gregorian_date_day_number i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- calendar model

  function automatic bit is_leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(int m, int y);
    case (m)
      2:             return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic int leaps_through(int n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic int jan1_day_num(int y);
    return (y - FirstYear) * 365 + leaps_through(y - 1) - leaps_through(FirstYear - 1);
  endfunction

  function automatic bit date_is_valid(int d, int m, int y);
    if (y < FirstYear || y > LastYear) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_length(m, y));
  endfunction

  function automatic int date_to_day_num(int d, int m, int y);
    int n;
    n = jan1_day_num(y);
    for (int i = 1; i < m; i++) n += month_length(i, y);
    return n + d - 1;
  endfunction

  function automatic void day_num_to_date(int n, output int d, output int m, output int y);
    int r;
    y = FirstYear + n / 366;
    while (y < LastYear && jan1_day_num(y + 1) <= n) y++;
    r = n - jan1_day_num(y);
    m = 1;
    while (m < 12 && r >= month_length(m, y)) begin
      r -= month_length(m, y);
      m++;
    end
    d = r + 1;
  endfunction

  function automatic date_result_t predict_date_result(
      gddn_pkg::action_e act, logic [4:0] da, logic [3:0] ma, logic [11:0] ya,
      logic [4:0] db, logic [3:0] mb, logic [11:0] yb, logic [17:0] cnt);
    date_result_t r;
    int n, c, rd, rm, ry;
    bit bad;
    r   = '0;
    bad = 1'b0;
    c   = int'($signed(cnt));
    case (act)
      gddn_pkg::ActDateToDays: begin
        if (date_is_valid(da, ma, ya)) r.days = 18'(date_to_day_num(da, ma, ya));
        else bad = 1'b1;
      end
      gddn_pkg::ActDateDiff: begin
        if (date_is_valid(da, ma, ya) && date_is_valid(db, mb, yb))
          r.days = 18'(date_to_day_num(da, ma, ya) - date_to_day_num(db, mb, yb));
        else bad = 1'b1;
      end
      default: begin
        n = c;
        if (act == gddn_pkg::ActDatePlus) begin
          if (date_is_valid(da, ma, ya)) n = date_to_day_num(da, ma, ya) + c;
          else bad = 1'b1;
        end
        if (!bad && (n < 0 || n > LastDayNum)) bad = 1'b1;
        if (!bad) begin
          day_num_to_date(n, rd, rm, ry);
          r.day   = 5'(rd);
          r.month = 4'(rm);
          r.year  = 12'(ry);
          r.days  = 18'(n);
        end
      end
    endcase
    if (bad) begin
      r     = '0;
      r.bad = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Called in the time step of a rising edge; returns in the step of the accepting edge.
  task automatic send_item(gddn_pkg::action_e act, logic [4:0] da, logic [3:0] ma,
                           logic [11:0] ya, logic [4:0] db, logic [3:0] mb,
                           logic [11:0] yb, logic [17:0] cnt);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0, cnt, yb, mb, db, ya, ma, da};
    expected_q.push_back(predict_date_result(act, da, ma, ya, db, mb, yb, cnt));
    n_sent++;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  function automatic void pick_valid_date(output logic [4:0] d, output logic [3:0] m,
                                          output logic [11:0] y);
    int yy, mm, len;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       yy = 1900;
        1:       yy = 2000;
        2:       yy = 2100;
        default: yy = 2200;
      endcase
    end else begin
      yy = $urandom_range(FirstYear, LastYear);
    end
    mm  = $urandom_range(1, 12);
    len = month_length(mm, yy);
    if ($urandom_range(0, 3) == 0) d = 5'(($urandom_range(0, 1) == 1) ? len : 1);
    else d = 5'($urandom_range(1, len));
    m = 4'(mm);
    y = 12'(yy);
  endfunction

  // Mostly well-formed items near interesting boundaries, with some broken ones and noise.
  task automatic send_random_item();
    logic [4:0]        da, db;
    logic [3:0]        ma, mb;
    logic [11:0]       ya, yb;
    logic [17:0]       cnt;
    gddn_pkg::action_e act;
    int                base, off, kind, len;
    act = gddn_pkg::action_e'($urandom_range(0, 3));
    pick_valid_date(da, ma, ya);
    pick_valid_date(db, mb, yb);
    base = date_to_day_num(da, ma, ya);
    len  = month_length(ma, ya);
    kind = $urandom_range(0, 9);
    if (act == gddn_pkg::ActDatePlus) begin
      if ($urandom_range(0, 2) == 0) off = int'($urandom_range(0, 800)) - 400;
      else off = int'($urandom_range(0, LastDayNum)) - base;
      cnt = 18'(off);
    end else if ($urandom_range(0, 7) == 0) begin
      cnt = 18'(($urandom_range(0, 1) == 1) ? LastDayNum - int'($urandom_range(0, 3))
                                            : int'($urandom_range(0, 3)));
    end else begin
      cnt = 18'($urandom_range(0, LastDayNum));
    end
    case (kind)
      0: begin
        {da, ma, ya, db, mb, yb} = 42'({$urandom, $urandom});
        cnt = 18'($urandom);
      end
      1: begin
        case ($urandom_range(0, 3))
          0: da = 5'(len + 1);
          1: ma = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(13, 15));
          2: ya = ($urandom_range(0, 1) == 1) ? 12'($urandom_range(0, FirstYear - 1))
                                              : 12'($urandom_range(LastYear + 1, 4095));
          default: db = 5'd0;
        endcase
      end
      2: begin
        off = ($urandom_range(0, 1) == 1) ? LastDayNum + int'($urandom_range(1, 5))
                                          : -int'($urandom_range(1, 5));
        cnt = 18'((act == gddn_pkg::ActDatePlus) ? off - base : off);
      end
      default: ;
    endcase
    send_item(act, da, ma, ya, db, mb, yb, cnt);
  endtask

  // ---------------------------------------------------------------- output side

  always @(posedge clk_i) begin
    if (hold_seq != seen_seq) begin
      seen_seq = hold_seq;
      hold_cnt = LongHold;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_cnt = $urandom_range(1, 5) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Handshake signals are stable at the falling edge, so a transaction seen here is the one
  // taken at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        n_errors++;
      end else begin
        exp_res = expected_q.pop_front();
        n_checked++;
        if (m_axis_tdata[4:0] !== exp_res.day) begin
          $error("out_day mismatch: expected %0d, actual %0d", exp_res.day, m_axis_tdata[4:0]);
          n_errors++;
        end
        if (m_axis_tdata[8:5] !== exp_res.month) begin
          $error("out_month mismatch: expected %0d, actual %0d",
                 exp_res.month, m_axis_tdata[8:5]);
          n_errors++;
        end
        if (m_axis_tdata[20:9] !== exp_res.year) begin
          $error("out_year mismatch: expected %0d, actual %0d",
                 exp_res.year, m_axis_tdata[20:9]);
          n_errors++;
        end
        if (m_axis_tdata[38:21] !== exp_res.days) begin
          $error("out_days mismatch: expected %0d, actual %0d",
                 $signed(exp_res.days), $signed(m_axis_tdata[38:21]));
          n_errors++;
        end
        if (m_axis_tuser !== exp_res.bad) begin
          $error("invalid mismatch: expected %0d, actual %0d", exp_res.bad, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    @(negedge clk_i);
    idle_en = 1'b0;
    @(posedge clk_i);
    // Range ends, leap days and malformed dates.
    send_item(gddn_pkg::ActDateToDays, 5'd1, 4'd1, 12'd1900, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd31, 4'd12, 12'd2200, 5'd31, 4'd15, 12'd4095,
              18'h3FFFF);
    send_item(gddn_pkg::ActDateToDays, 5'd29, 4'd2, 12'd2000, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd29, 4'd2, 12'd1900, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd29, 4'd2, 12'd2100, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd29, 4'd2, 12'd2200, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd0, 4'd6, 12'd1950, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd31, 4'd4, 12'd1950, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd10, 4'd0, 12'd1950, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd10, 4'd13, 12'd1950, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd31, 4'd12, 12'd1899, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDateToDays, 5'd1, 4'd1, 12'd2201, 5'd0, 4'd0, 12'd0, 18'd0);
    // Day numbers at and beyond both ends of the range.
    send_item(gddn_pkg::ActDaysToDate, 5'd0, 4'd0, 12'd0, 5'd0, 4'd0, 12'd0, 18'd0);
    send_item(gddn_pkg::ActDaysToDate, 5'd0, 4'd0, 12'd0, 5'd0, 4'd0, 12'd0,
              18'(LastDayNum));
    send_item(gddn_pkg::ActDaysToDate, 5'd0, 4'd0, 12'd0, 5'd0, 4'd0, 12'd0,
              18'(LastDayNum + 1));
    send_item(gddn_pkg::ActDaysToDate, 5'd0, 4'd0, 12'd0, 5'd0, 4'd0, 12'd0, 18'h3FFFF);
    send_item(gddn_pkg::ActDaysToDate, 5'd0, 4'd0, 12'd0, 5'd0, 4'd0, 12'd0, 18'h20000);
    send_item(gddn_pkg::ActDaysToDate, 5'd0, 4'd0, 12'd0, 5'd0, 4'd0, 12'd0, 18'h1FFFF);
    // Offsets across a skipped leap day, a real one, and off either end.
    send_item(gddn_pkg::ActDatePlus, 5'd28, 4'd2, 12'd2100, 5'd0, 4'd0, 12'd0, 18'd1);
    send_item(gddn_pkg::ActDatePlus, 5'd28, 4'd2, 12'd2000, 5'd0, 4'd0, 12'd0, 18'd1);
    send_item(gddn_pkg::ActDatePlus, 5'd1, 4'd1, 12'd1900, 5'd0, 4'd0, 12'd0, 18'h3FFFF);
    send_item(gddn_pkg::ActDatePlus, 5'd31, 4'd12, 12'd2200, 5'd0, 4'd0, 12'd0, 18'd1);
    send_item(gddn_pkg::ActDatePlus, 5'd1, 4'd1, 12'd1900, 5'd0, 4'd0, 12'd0,
              18'(LastDayNum));
    send_item(gddn_pkg::ActDatePlus, 5'd30, 4'd2, 12'd2000, 5'd0, 4'd0, 12'd0, 18'd5);
    // Differences at full span both ways and with either date malformed.
    send_item(gddn_pkg::ActDateDiff, 5'd31, 4'd12, 12'd2200, 5'd1, 4'd1, 12'd1900, 18'd0);
    send_item(gddn_pkg::ActDateDiff, 5'd1, 4'd1, 12'd1900, 5'd31, 4'd12, 12'd2200, 18'd0);
    send_item(gddn_pkg::ActDateDiff, 5'd1, 4'd1, 12'd1900, 5'd29, 4'd2, 12'd2100, 18'd0);
    send_item(gddn_pkg::ActDateDiff, 5'd0, 4'd1, 12'd1900, 5'd1, 4'd1, 12'd1900, 18'd0);
    s_axis_tvalid <= 1'b0;
  endtask

  // The receiver stalls long enough for the pipeline to fill and push back on the input.
  task automatic test_output_backpressure();
    @(negedge clk_i);
    idle_en = 1'b0;
    hold_seq++;
    @(posedge clk_i);
    repeat (40) send_random_item();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_random_items(int count, bit with_idle);
    @(negedge clk_i);
    idle_en = with_idle;
    @(posedge clk_i);
    repeat (count) send_random_item();
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    int waited;
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_cases();
    test_random_items(450, 1'b1);
    test_output_backpressure();
    test_random_items(450, 1'b1);
    test_random_items(150, 1'b0);

    waited = 0;
    while (expected_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      n_errors++;
    end
    repeat (2 * PipeLatency) @(posedge clk_i);

    $display("Sent %0d transactions over all four actions, with range ends, leap days,",
             n_sent);
    $display("malformed dates and out-of-range day numbers; %0d results checked.", n_checked);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
